// File: design/i2cebm_pkg.sv
// i2cebm_pkg: shared types and constants for the I2C EEPROM byte master.
// Used by i2cebm_core and i2c_eeprom_byte_master_top; no dependencies.
package i2cebm_pkg;

  typedef enum logic [3:0] {
    OP_END     = 4'd0,
    OP_START   = 4'd1,
    OP_TX_DEVW = 4'd2,
    OP_TX_DEVR = 4'd3,
    OP_TX_ADDR = 4'd4,
    OP_TX_DATA = 4'd5,
    OP_ACK     = 4'd6,
    OP_STOP    = 4'd7,
    OP_RESTART = 4'd8,
    OP_RX      = 4'd9,
    OP_NOACK   = 4'd10,
    OP_RECOVER = 4'd11
  } seg_op_e;

  typedef enum logic [1:0] {
    CMD_STEP  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  localparam int unsigned  PROG_LEN          = 12;
  localparam logic [7:0]   DEV_WR_MASK       = 8'hFE;
  localparam logic [7:0]   DEV_RD_BIT        = 8'h01;
  localparam logic [15:0]  RECOVERY_RESET    = 16'd10000;
  localparam logic [0:0]   REG_RECOVERY      = 1'b0;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] read_data;
  } step_res_t;

  function automatic seg_op_e op_at(input logic read_mode, input logic [3:0] seg);
    seg_op_e op;
    op = OP_END;
    if (read_mode) begin
      case (seg)
        4'd0:    op = OP_START;
        4'd1:    op = OP_TX_DEVW;
        4'd2:    op = OP_ACK;
        4'd3:    op = OP_TX_ADDR;
        4'd4:    op = OP_ACK;
        4'd5:    op = OP_RESTART;
        4'd6:    op = OP_TX_DEVR;
        4'd7:    op = OP_ACK;
        4'd8:    op = OP_RX;
        4'd9:    op = OP_NOACK;
        4'd10:   op = OP_STOP;
        default: op = OP_END;
      endcase
    end else begin
      case (seg)
        4'd0:    op = OP_START;
        4'd1:    op = OP_TX_DEVW;
        4'd2:    op = OP_ACK;
        4'd3:    op = OP_TX_ADDR;
        4'd4:    op = OP_ACK;
        4'd5:    op = OP_TX_DATA;
        4'd6:    op = OP_ACK;
        4'd7:    op = OP_STOP;
        4'd8:    op = OP_RECOVER;
        default: op = OP_END;
      endcase
    end
    return op;
  endfunction

endpackage

// File: design/i2cebm_core.sv
// i2cebm_core: sequencer state and the single-pass step logic of the master.
// Depends on i2cebm_pkg.
module i2cebm_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_en_i,
  input  logic [1:0]             operation_i,
  input  logic [7:0]             device_select_i,
  input  logic [7:0]             word_address_i,
  input  logic [7:0]             write_data_i,
  input  logic                   sda_in_i,
  input  logic [15:0]            recovery_ticks_i,
  output i2cebm_pkg::step_res_t  res_o
);

  logic [5:0]  step_q, step_d;
  logic [2:0]  bc_q, bc_d;
  logic [7:0]  sb_q, sb_d;
  logic [7:0]  dev_q, dev_d;
  logic [7:0]  addr_q, addr_d;
  logic [7:0]  data_q, data_d;
  logic        rm_q, rm_d;
  logic [15:0] rc_q, rc_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  logic        fin;

  always_comb begin
    logic [1:0]          sub;
    logic [3:0]          seg;
    logic [3:0]          nxt;
    logic                adv;
    logic [7:0]          src;
    i2cebm_pkg::seg_op_e op;
    i2cebm_pkg::seg_op_e nop;

    step_d = step_q;
    bc_d   = bc_q;
    sb_d   = sb_q;
    dev_d  = dev_q;
    addr_d = addr_q;
    data_d = data_q;
    rm_d   = rm_q;
    rc_d   = rc_q;
    scl_d  = scl_q;
    sda_d  = sda_q;
    fin    = 1'b0;
    adv    = 1'b0;
    src    = data_q;

    if (step_q == 6'd0 && (operation_i == i2cebm_pkg::CMD_WRITE ||
                           operation_i == i2cebm_pkg::CMD_READ)) begin
      dev_d  = device_select_i;
      addr_d = word_address_i;
      rm_d   = (operation_i == i2cebm_pkg::CMD_READ);
      data_d = rm_d ? 8'd0 : write_data_i;
      bc_d   = 3'd0;
      step_d = 6'd4;
    end

    sub = step_d[1:0];
    seg = step_d[5:2] - 4'd1;
    nxt = step_d[5:2];
    op  = i2cebm_pkg::op_at(rm_d, seg);
    nop = i2cebm_pkg::op_at(rm_d, nxt);

    if (step_d != 6'd0) begin
      unique case (op)
        i2cebm_pkg::OP_START: begin
          case (sub)
            2'd0:    begin scl_d = 1'b1; step_d[1:0] = 2'd1; end
            2'd1:    begin sda_d = 1'b1; step_d[1:0] = 2'd2; end
            default: begin sda_d = 1'b0; adv = 1'b1; end
          endcase
        end
        i2cebm_pkg::OP_TX_DEVW, i2cebm_pkg::OP_TX_DEVR,
        i2cebm_pkg::OP_TX_ADDR, i2cebm_pkg::OP_TX_DATA: begin
          if (op == i2cebm_pkg::OP_TX_DEVW)      src = dev_d & i2cebm_pkg::DEV_WR_MASK;
          else if (op == i2cebm_pkg::OP_TX_DEVR) src = dev_d | i2cebm_pkg::DEV_RD_BIT;
          else if (op == i2cebm_pkg::OP_TX_ADDR) src = addr_d;
          else                                   src = data_d;
          case (sub)
            2'd0: begin
              if (bc_d == 3'd0) sb_d = src;
              scl_d = 1'b0;
              step_d[1:0] = 2'd1;
            end
            2'd1: begin
              sda_d = sb_d[3'd7 - bc_d];
              step_d[1:0] = 2'd2;
            end
            2'd2: begin
              scl_d = 1'b1;
              bc_d  = bc_d + 3'd1;
              if (bc_d == 3'd0) adv = 1'b1;
              else step_d[1:0] = 2'd0;
            end
            default: adv = 1'b1;
          endcase
        end
        i2cebm_pkg::OP_ACK: begin
          case (sub)
            2'd0:    begin scl_d = 1'b0; step_d[1:0] = 2'd1; end
            2'd1:    begin sda_d = 1'b1; step_d[1:0] = 2'd2; end
            2'd2:    begin scl_d = 1'b1; step_d[1:0] = 2'd3; end
            default: adv = !sda_in_i;
          endcase
        end
        i2cebm_pkg::OP_STOP: begin
          case (sub)
            2'd0:    begin scl_d = 1'b0; step_d[1:0] = 2'd1; end
            2'd1:    begin sda_d = 1'b0; step_d[1:0] = 2'd2; end
            2'd2:    begin scl_d = 1'b1; step_d[1:0] = 2'd3; end
            default: begin sda_d = 1'b1; adv = 1'b1; end
          endcase
        end
        i2cebm_pkg::OP_RESTART: begin
          case (sub)
            2'd0:    begin scl_d = 1'b0; step_d[1:0] = 2'd1; end
            2'd1:    begin sda_d = 1'b1; step_d[1:0] = 2'd2; end
            2'd2:    begin scl_d = 1'b1; step_d[1:0] = 2'd3; end
            default: begin sda_d = 1'b0; adv = 1'b1; end
          endcase
        end
        i2cebm_pkg::OP_RX: begin
          if (sub == 2'd0) begin
            if (bc_d == 3'd0) sb_d = 8'd0;
            scl_d = 1'b0;
            step_d[1:0] = 2'd1;
          end else begin
            scl_d = 1'b1;
            if (sda_in_i) sb_d[3'd7 - bc_d] = 1'b1;
            bc_d = bc_d + 3'd1;
            if (bc_d == 3'd0) begin
              data_d = sb_d;
              adv    = 1'b1;
            end else begin
              step_d[1:0] = 2'd0;
            end
          end
        end
        i2cebm_pkg::OP_NOACK: begin
          case (sub)
            2'd0:    begin scl_d = 1'b0; step_d[1:0] = 2'd1; end
            2'd1:    begin sda_d = 1'b1; step_d[1:0] = 2'd2; end
            default: begin scl_d = 1'b1; adv = 1'b1; end
          endcase
        end
        i2cebm_pkg::OP_RECOVER: begin
          if (rc_d == 16'd0) begin
            step_d = 6'd0;
            fin    = 1'b1;
          end else begin
            rc_d = rc_d - 16'd1;
          end
        end
        default: begin
          step_d = 6'd0;
          fin    = 1'b1;
        end
      endcase

      if (adv) begin
        bc_d = 3'd0;
        if (nop == i2cebm_pkg::OP_END) begin
          step_d = 6'd0;
          fin    = 1'b1;
        end else begin
          step_d = {nxt + 4'd1, 2'b00};
          if (nop == i2cebm_pkg::OP_RECOVER) rc_d = recovery_ticks_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 6'd0;
      bc_q   <= 3'd0;
      sb_q   <= 8'd0;
      dev_q  <= 8'd0;
      addr_q <= 8'd0;
      data_q <= 8'd0;
      rm_q   <= 1'b0;
      rc_q   <= 16'd0;
      scl_q  <= 1'b1;
      sda_q  <= 1'b1;
    end else if (step_en_i) begin
      step_q <= step_d;
      bc_q   <= bc_d;
      sb_q   <= sb_d;
      dev_q  <= dev_d;
      addr_q <= addr_d;
      data_q <= data_d;
      rm_q   <= rm_d;
      rc_q   <= rc_d;
      scl_q  <= scl_d;
      sda_q  <= sda_d;
    end
  end

  assign res_o.scl       = scl_d;
  assign res_o.sda       = sda_d;
  assign res_o.busy      = (step_d != 6'd0);
  assign res_o.done      = fin;
  assign res_o.read_data = rm_d ? data_d : 8'd0;

endmodule

// File: design/i2c_eeprom_byte_master_top.sv
// i2c_eeprom_byte_master_top: stream-in bus steps, stream-out line levels, APB register.
// Depends on i2cebm_pkg and i2cebm_core.
// The result word of each accepted input word is registered into the output register.
// Throughput: one word per cycle; input is taken whenever the output register is empty or
// being drained in the same cycle.
// Reset (rst_ni low, async): sequencer idle, lines high, output empty, recovery 10000.
module i2c_eeprom_byte_master_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [7:0] device_select, [15:8] word_address, [23:16] write_data, [24] sda_in
  input  logic [31:0] s_axis_tdata_i,
  // [1:0] operation
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] scl_out, [1] sda_out, [2] busy_res, [10:3] read_data
  output logic [15:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0]           recovery_q;
  logic                  in_fire;
  logic                  out_vld_q;
  i2cebm_pkg::step_res_t res;
  i2cebm_pkg::step_res_t res_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == i2cebm_pkg::REG_RECOVERY) ? {16'd0, recovery_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recovery_q <= i2cebm_pkg::RECOVERY_RESET;
    end else if (psel && penable && pwrite && paddr[2] == i2cebm_pkg::REG_RECOVERY) begin
      recovery_q <= pwdata[15:0];
    end
  end

  assign s_axis_tready_o = !out_vld_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  i2cebm_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_en_i        (in_fire),
    .operation_i      (s_axis_tuser_i),
    .device_select_i  (s_axis_tdata_i[7:0]),
    .word_address_i   (s_axis_tdata_i[15:8]),
    .write_data_i     (s_axis_tdata_i[23:16]),
    .sda_in_i         (s_axis_tdata_i[24]),
    .recovery_ticks_i (recovery_q),
    .res_o            (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (in_fire) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {5'd0, res_q.read_data, res_q.busy, res_q.sda, res_q.scl};
  assign m_axis_tlast_o  = res_q.done;

endmodule
